// File: design/ipv4_longest_prefix_match_macros.svh
// Assertion macros for the IPv4 longest prefix match block.
// Taken in by ipv4_longest_prefix_match.sv, the RTL file that carries concurrent assertions.
`ifndef IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_MACROS_SVH

// check a property on every rising clock edge outside reset
`define LPM_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define LPM_CHECK_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/iplpm_pkg.sv
// Types, codes and helper functions for the IPv4 longest prefix match block.
// Used by iplpm_cell, ipv4_longest_prefix_match and the testbench; depends on nothing.
`default_nettype none
package iplpm_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W = 6;
   localparam int TAG_W = 4;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_LOOKUP = 2'd3
   } status_type;

   typedef struct packed {
      logic cmd;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0] prefix_length;
   } req_type;

   typedef struct packed {
      status_type status;
      logic found;
      logic [TAG_W-1:0] match_index;
      logic [ADDR_W-1:0] match_network;
      logic [LEN_W-1:0] match_length;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic [ADDR_W-1:0] address;
      logic found;
      logic [TAG_W-1:0] index;
      logic [ADDR_W-1:0] network;
      logic [LEN_W-1:0] length;
   } search_type;

   typedef struct packed {
      logic en;
      logic [ADDR_W-1:0] network;
      logic [LEN_W-1:0] length;
   } route_write_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage
`default_nettype wire

// File: design/iplpm_cell.sv
// One route cell: holds a stored route and compares the passing lookup against it.
// Depends on iplpm_pkg.
`default_nettype none
module iplpm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire iplpm_pkg::route_write_type  wr,
   input  wire logic                        valid,
   input  wire iplpm_pkg::search_type       search_prev,
   output iplpm_pkg::search_type            search_next
);

   localparam logic [iplpm_pkg::TAG_W-1:0] CELL_TAG = iplpm_pkg::TAG_W'(CELL_INDEX % 16);

   logic [iplpm_pkg::ADDR_W-1:0] network_ff;
   logic [iplpm_pkg::LEN_W-1:0]  length_ff;
   iplpm_pkg::search_type        search_ff;
   iplpm_pkg::search_type        search_in;
   logic                         match;
   logic                         take;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         network_ff <= wr.network;
         length_ff <= wr.length;
      end
   end

   always_comb begin
      match = valid &&
              ((search_prev.address & iplpm_pkg::prefix_mask(length_ff)) == network_ff);
      take = search_prev.active && match &&
             (!search_prev.found || (length_ff > search_prev.length));
      search_in = search_prev;
      if (take) begin
         search_in.found = 1'b1;
         search_in.index = CELL_TAG;
         search_in.network = network_ff;
         search_in.length = length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff.active <= 1'b0;
      end else begin
         search_ff.active <= search_in.active;
      end
      search_ff.address <= search_in.address;
      search_ff.found <= search_in.found;
      search_ff.index <= search_in.index;
      search_ff.network <= search_in.network;
      search_ff.length <= search_in.length;
   end

   assign search_next = search_ff;

endmodule
`default_nettype wire

// File: design/ipv4_longest_prefix_match.sv
// Add item: result strobed in the cycle after accept; an add may be accepted every cycle
// while busy is low. Lookup item: the search walks through the row of route cells, registered
// in each cell in turn and then in the result register; busy stays high meanwhile.
// Reset clears the route count, which empties the table at once; the receiver
// cannot stall and takes each result in its single strobe cycle.
`default_nettype none
`include "ipv4_longest_prefix_match_macros.svh"
module ipv4_longest_prefix_match #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire iplpm_pkg::req_type  req_item,
   output logic                     rsp_strobe,
   output iplpm_pkg::rsp_type       rsp_item
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        busy_ff;
   logic                        busy_in;
   logic                        rsp_strobe_ff;
   logic                        rsp_strobe_in;
   iplpm_pkg::rsp_type          rsp_ff;
   iplpm_pkg::rsp_type          rsp_in;
   logic                        accept;
   logic                        is_add;
   logic                        is_lookup;
   logic                        invalid;
   logic                        full;
   logic                        add_ok;
   iplpm_pkg::search_type       head;
   iplpm_pkg::search_type       tail;
   iplpm_pkg::search_type       stage [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]      stage_active;

   assign accept = start && !busy_ff;
   assign is_add = accept && (req_item.cmd == iplpm_pkg::CMD_ADD);
   assign is_lookup = accept && (req_item.cmd == iplpm_pkg::CMD_LOOKUP);
   assign invalid = (req_item.prefix_length > iplpm_pkg::MAX_LEN) ||
                    ((req_item.address & ~iplpm_pkg::prefix_mask(req_item.prefix_length))
                     != '0);
   assign full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign add_ok = is_add && !invalid && !full;

   always_comb begin
      head.active = is_lookup;
      head.address = req_item.address;
      head.found = 1'b0;
      head.index = '0;
      head.network = '0;
      head.length = '0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      iplpm_pkg::route_write_type wr;
      logic                       valid;
      assign wr.en = add_ok && (count_ff == CNT_W'(i));
      assign wr.network = req_item.address;
      assign wr.length = req_item.prefix_length;
      assign valid = (count_ff > CNT_W'(i));
      assign stage_active[i] = stage[i].active;
      if (i == 0) begin : g_first
         iplpm_cell #(.CELL_INDEX(i)) u_cell (
            .clock(clock),
            .reset(reset),
            .wr(wr),
            .valid(valid),
            .search_prev(head),
            .search_next(stage[i])
         );
      end else begin : g_rest
         iplpm_cell #(.CELL_INDEX(i)) u_cell (
            .clock(clock),
            .reset(reset),
            .wr(wr),
            .valid(valid),
            .search_prev(stage[i-1]),
            .search_next(stage[i])
         );
      end
   end

   assign tail = stage[TABLE_DEPTH-1];

   always_comb begin
      count_in = count_ff + CNT_W'(add_ok);
      busy_in = busy_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      if (is_lookup) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
      if (is_add) begin
         rsp_strobe_in = 1'b1;
         rsp_in.found = 1'b0;
         rsp_in.match_index = '0;
         rsp_in.match_network = '0;
         rsp_in.match_length = '0;
         if (invalid) begin
            rsp_in.status = iplpm_pkg::STATUS_INVALID;
         end else if (full) begin
            rsp_in.status = iplpm_pkg::STATUS_FULL;
         end else begin
            rsp_in.status = iplpm_pkg::STATUS_ADDED;
         end
      end else if (tail.active) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = iplpm_pkg::STATUS_LOOKUP;
         rsp_in.found = tail.found;
         rsp_in.match_index = tail.index;
         rsp_in.match_network = tail.network;
         rsp_in.match_length = tail.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   `LPM_CHECK(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH), "route count overflow")
   `LPM_CHECK(a_one_lookup, clock, reset, $onehot0(stage_active), "two lookups in the cell row")
   `LPM_CHECK(a_tail_busy, clock, reset, !tail.active || busy_ff, "lookup finished while idle")
   `LPM_CHECK(a_strobe_idle, clock, reset, !rsp_strobe_ff || !busy_ff, "result while lookup busy")
   `LPM_CHECK_NEXT(a_add_result, clock, reset, is_add, rsp_strobe_ff, "add item without result")

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for ipv4_longest_prefix_match: drives add and lookup items,
// predicts each result from a route table of its own and compares it field by field.
// Depends on iplpm_pkg and the ipv4_longest_prefix_match RTL.
module testbench;
   import iplpm_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 740;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;

   logic [ADDR_W-1:0] route_net [TABLE_DEPTH];
   logic [LEN_W-1:0] route_len [TABLE_DEPTH];
   int unsigned routes_stored = 0;
   rsp_type pending_results [$];

   int error_count = 0;
   int cycle_count = 0;
   int add_count = 0;
   int lookup_count = 0;
   int hit_count = 0;
   int quiet_left = 0;

   ipv4_longest_prefix_match #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] network_mask(input int unsigned len);
      logic [ADDR_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < len && b < ADDR_W; b++) mask[ADDR_W-1-b] = 1'b1;
      return mask;
   endfunction

   // apply one item to the route table and return the result it must produce
   function automatic rsp_type resolve_route(input req_type item);
      rsp_type r;
      int unsigned len;
      r = '0;
      len = item.prefix_length;
      if (item.cmd == CMD_ADD) begin
         add_count++;
         if (len > 32 || (item.address & ~network_mask(len)) != '0) begin
            r.status = STATUS_INVALID;
         end else if (routes_stored >= TABLE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            route_net[routes_stored] = item.address;
            route_len[routes_stored] = item.prefix_length;
            routes_stored++;
            r.status = STATUS_ADDED;
         end
      end else begin
         lookup_count++;
         r.status = STATUS_LOOKUP;
         for (int i = 0; i < routes_stored; i++) begin
            if ((item.address & network_mask(route_len[i])) == route_net[i] &&
                (!r.found || route_len[i] > r.match_length)) begin
               r.found = 1'b1;
               r.match_index = TAG_W'(i);
               r.match_network = route_net[i];
               r.match_length = route_len[i];
            end
         end
         if (r.found) hit_count++;
      end
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding, status %0d", rsp_item.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_item.found);
               error_count++;
            end
            if (rsp_item.match_index !== want.match_index) begin
               $error("match_index: expected %0d, got %0d",
                      want.match_index, rsp_item.match_index);
               error_count++;
            end
            if (rsp_item.match_network !== want.match_network) begin
               $error("match_network: expected %h, got %h",
                      want.match_network, rsp_item.match_network);
               error_count++;
            end
            if (rsp_item.match_length !== want.match_length) begin
               $error("match_length: expected %0d, got %0d",
                      want.match_length, rsp_item.match_length);
               error_count++;
            end
         end
      end
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(8, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 17);
      end
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_item = item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(resolve_route(item));
   endtask

   task automatic send_add(input logic [ADDR_W-1:0] address, input logic [LEN_W-1:0] len);
      req_type item;
      item.cmd = CMD_ADD;
      item.address = address;
      item.prefix_length = len;
      send_item(item);
   endtask

   task automatic send_lookup(input logic [ADDR_W-1:0] address);
      req_type item;
      item.cmd = CMD_LOOKUP;
      item.address = address;
      item.prefix_length = LEN_W'($urandom);
      send_item(item);
   endtask

   task automatic send_valid_route();
      int unsigned len;
      len = $urandom_range(1, 32);
      send_add($urandom & network_mask(len), LEN_W'(len));
   endtask

   // over-long prefix or host bits set
   task automatic send_bad_route();
      logic [ADDR_W-1:0] address;
      int unsigned len;
      address = $urandom;
      len = $urandom_range(0, 63);
      if (len == 32) len = $urandom_range(33, 63);
      else if (len < 32) address[$urandom_range(0, 31 - len)] = 1'b1;
      send_add(address, LEN_W'(len));
   endtask

   // mostly destinations inside a stored route, some with one bit flipped
   function automatic logic [ADDR_W-1:0] random_destination();
      logic [ADDR_W-1:0] dest;
      int unsigned pick;
      int unsigned flip;
      dest = $urandom;
      if (routes_stored > 0 && $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, routes_stored - 1);
         dest = route_net[pick] | (dest & ~network_mask(route_len[pick]));
         if ($urandom_range(0, 3) == 0) begin
            flip = $urandom_range(0, ADDR_W - 1);
            dest[flip] = ~dest[flip];
         end
      end
      return dest;
   endfunction

   task automatic test_empty_table();
      send_lookup(32'h0000_0000);
      send_lookup(32'hFFFF_FFFF);
   endtask

   task automatic test_add_screening();
      send_add(32'h0A00_0000, 6'd33);
      send_add(32'hFFFF_FFFF, 6'd63);
      send_add(32'hC0A8_0101, 6'd24);
      send_add(32'h0000_0001, 6'd0);
      send_add(32'hFFFF_FFFF, 6'd32);
      send_add(32'h0A00_0000, 6'd8);
      send_add(32'h0A01_0000, 6'd16);
      send_add(32'h0A01_0000, 6'd16);
      send_add(32'h8000_0000, 6'd1);
   endtask

   task automatic test_directed_lookups();
      send_lookup(32'h0A01_0203);
      send_lookup(32'h0A02_0304);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h8000_0001);
      send_lookup(32'h0B00_0000);
   endtask

   task automatic test_random_growth();
      int unsigned roll;
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5 && routes_stored < TABLE_DEPTH - 1) send_valid_route();
         else if (roll < 15) send_bad_route();
         else send_lookup(random_destination());
      end
   endtask

   task automatic test_default_route();
      send_add(32'h0000_0000, 6'd0);
      while (routes_stored < TABLE_DEPTH) send_valid_route();
      send_add(32'h0A00_0000, 6'd8);
      send_add(32'h0A00_0000, 6'd40);
      send_lookup(32'h0B00_0000);
      send_lookup(32'h0000_0000);
   endtask

   task automatic test_random_full_table();
      int unsigned roll;
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) send_valid_route();
         else if (roll < 20) send_bad_route();
         else send_lookup(random_destination());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_add_screening();
      test_directed_lookups();
      test_random_growth();
      test_default_route();
      test_random_full_table();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      $display("ran %0d adds and %0d lookups (%0d hits), filling all %0d routes",
               add_count, lookup_count, hit_count, routes_stored);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/iplpm_pkg.sv
design/iplpm_cell.sv
design/ipv4_longest_prefix_match.sv
verif/testbench.sv
